>>> rtl/lfu_pkg.sv
// Shared types, codes and constants of the LFU cache table.
package lfu_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int KEY_W  = 32;
  localparam int SIZE_W = 24;
  localparam int CNT_W  = 16;
  localparam int NODE_W = 8;
  localparam int TYPE_W = 2;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Request types; any other code is handled as a data request.
  localparam logic [TYPE_W-1:0] REQ_REPL    = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_PRELOAD = 2'd2;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_SERVED    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FORWARDED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REPLICATED = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PRELOADED = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DROPPED   = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic load;    // latch the accepted item and restart the walk
    logic scan;    // read the entry at the walk index and advance
    logic commit;  // update the table and load the result register
  } cmd_t;

  typedef struct packed {
    logic last_addr;  // the walk index points at the last entry
  } stat_t;

endpackage

>>> rtl/lfu_ctrl.sv
// Controller state machine of the LFU cache table.
module lfu_ctrl import lfu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_addr) begin
          state_nxt = S_DRAIN;
        end
      end
      // The read of the last entry is compared in this cycle.
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_rise_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

endmodule

>>> rtl/lfu_dp.sv
// Datapath of the LFU cache table: entry memory, walk trackers, counters, result register.
module lfu_dp import lfu_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data,
  input  logic [TYPE_W-1:0] in_req_type,
  input  logic [KEY_W-1:0]  in_data_key,
  input  logic [SIZE_W-1:0] in_item_size,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic [ACT_W-1:0]  out_action,
  output logic [SIZE_W-1:0] out_served_size,
  output logic              out_evicted_valid,
  output logic [KEY_W-1:0]  out_evicted_key,
  output logic [NODE_W-1:0] out_source_node,
  output logic [STAT_W-1:0] out_hit_count,
  output logic [STAT_W-1:0] out_miss_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [NODE_W-1:0] node_id_r;

  logic [TYPE_W-1:0] req_type_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [SIZE_W-1:0] req_size_r;

  entry_t             entry_mem_r [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;

  logic [IDX_W-1:0] idx_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  entry_t           rd_q_r;
  logic             rd_entry_v;

  // Walk trackers: first key match, first free slot, least-count victim.
  logic              match_hit_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [SIZE_W-1:0] match_size_r;
  logic [CNT_W-1:0]  match_cnt_r;
  logic              free_hit_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              vic_hit_r;
  logic [IDX_W-1:0]  vic_idx_r;
  logic [KEY_W-1:0]  vic_key_r;
  logic [CNT_W-1:0]  vic_cnt_r;

  logic [STAT_W-1:0] hits_r, hits_nxt;
  logic [STAT_W-1:0] misses_r, misses_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_slot;
  entry_t            wr_entry;
  logic              use_match;
  logic [ACT_W-1:0]  act;
  logic [SIZE_W-1:0] served;
  logic              ev_valid;
  logic [KEY_W-1:0]  ev_key;
  logic [NODE_W-1:0] src;

  logic [ACT_W-1:0]  out_action_r;
  logic [SIZE_W-1:0] out_served_size_r;
  logic              out_evicted_valid_r;
  logic [KEY_W-1:0]  out_evicted_key_r;
  logic [NODE_W-1:0] out_source_node_r;

  assign stat.last_addr = (idx_r == LAST_IDX);
  assign rd_entry_v     = valid_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= '0;
    end else if (cfg_wr_en) begin
      node_id_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      req_key_r  <= in_data_key;
      req_size_r <= in_item_size;
    end
  end

  // Single-port walk: one entry read per cycle, compared in the cycle after its read.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      entry_mem_r[wr_slot] <= wr_entry;
    end
    if (cmd.scan) begin
      rd_q_r <= entry_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.scan && !stat.last_addr) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      vic_hit_r   <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_entry_v) begin
        if (!match_hit_r && rd_q_r.key == req_key_r) begin
          match_hit_r  <= 1'b1;
          match_idx_r  <= rd_idx_r;
          match_size_r <= rd_q_r.size;
          match_cnt_r  <= rd_q_r.count;
        end
        if (!vic_hit_r || rd_q_r.count < vic_cnt_r ||
            (rd_q_r.count == vic_cnt_r && rd_q_r.key < vic_key_r)) begin
          vic_hit_r <= 1'b1;
          vic_idx_r <= rd_idx_r;
          vic_key_r <= rd_q_r.key;
          vic_cnt_r <= rd_q_r.count;
        end
      end else if (!free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_slot    = match_idx_r;
    wr_entry   = '{key: req_key_r, size: req_size_r, count: '0};
    valid_nxt  = valid_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    act        = ACT_SERVED;
    served     = '0;
    ev_valid   = 1'b0;
    ev_key     = '0;
    src        = '0;
    // A match on the entry being evicted no longer counts as a match.
    use_match  = match_hit_r && !(vic_hit_r && match_idx_r == vic_idx_r);
    case (req_type_r)
      REQ_REPL: begin
        act            = ACT_REPLICATED;
        served         = req_size_r;
        wr_en          = 1'b1;
        wr_entry.count = CNT_W'(1);
        if (vic_hit_r) begin
          ev_valid             = 1'b1;
          ev_key               = vic_key_r;
          valid_nxt[vic_idx_r] = 1'b0;
        end
        // The evicted slot competes with the first free slot for lowest index.
        if (use_match) begin
          wr_slot = match_idx_r;
        end else if (vic_hit_r) begin
          wr_slot = (free_hit_r && free_idx_r < vic_idx_r) ? free_idx_r : vic_idx_r;
        end else begin
          wr_slot = free_idx_r;
        end
        valid_nxt[wr_slot] = 1'b1;
      end
      REQ_PRELOAD: begin
        if (match_hit_r || free_hit_r) begin
          act                = ACT_PRELOADED;
          wr_en              = 1'b1;
          wr_slot            = match_hit_r ? match_idx_r : free_idx_r;
          valid_nxt[wr_slot] = 1'b1;
        end else begin
          act = ACT_DROPPED;
        end
      end
      default: begin
        // Data request, also taken for the unused type code.
        src = node_id_r;
        if (match_hit_r) begin
          act            = ACT_SERVED;
          served         = match_size_r;
          wr_en          = 1'b1;
          wr_slot        = match_idx_r;
          wr_entry.size  = match_size_r;
          wr_entry.count = (match_cnt_r == COUNT_MAX) ? match_cnt_r
                                                      : match_cnt_r + 1'b1;
          hits_nxt       = hits_r + 1'b1;
        end else begin
          act        = ACT_FORWARDED;
          misses_nxt = misses_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      valid_r  <= valid_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action_r        <= act;
      out_served_size_r   <= served;
      out_evicted_valid_r <= ev_valid;
      out_evicted_key_r   <= ev_key;
      out_source_node_r   <= src;
    end
  end

  assign out_action        = out_action_r;
  assign out_served_size   = out_served_size_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_key   = out_evicted_key_r;
  assign out_source_node   = out_source_node_r;
  assign out_hit_count     = hits_r;
  assign out_miss_count    = misses_r;

  a_stats_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> ($stable(hits_r) && $stable(misses_r)))
    else $error("hit or miss counter changed outside a commit");

  a_one_stat_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ($countones({hits_r != $past(hits_r), misses_r != $past(misses_r)}) <= 1))
    else $error("hit and miss counters both moved on one item");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && wr_en) |=> valid_r[$past(wr_slot)])
    else $error("written entry not marked valid");

endmodule

>>> rtl/lfu_replica_cache_table.sv
// LFU cache table top level: an item is accepted, then the entry memory is walked one
// entry per cycle on its single read port, the last read is compared in the drain
// state, and the table, counters and result register are updated in the commit state;
// no new item is taken until that commit, and the commit waits while the previous
// result is still not taken. The table holds CAPACITY entries, 32 by default.
// Entry valid bits clear at reset; no clearing pass is needed.
module lfu_replica_cache_table import lfu_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TYPE_W-1:0] in_req_type,
  input  logic [KEY_W-1:0]  in_data_key,
  input  logic [SIZE_W-1:0] in_item_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ACT_W-1:0]  out_action,
  output logic [SIZE_W-1:0] out_served_size,
  output logic              out_evicted_valid,
  output logic [KEY_W-1:0]  out_evicted_key,
  output logic [NODE_W-1:0] out_source_node,
  output logic [STAT_W-1:0] out_hit_count,
  output logic [STAT_W-1:0] out_miss_count
);

  cmd_t  cmd;
  stat_t stat;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfu_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_data_key       (in_data_key),
    .in_item_size      (in_item_size),
    .cmd               (cmd),
    .stat              (stat),
    .out_action        (out_action),
    .out_served_size   (out_served_size),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_source_node   (out_source_node),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count)
  );

endmodule
